@@ sv/itoa_fmt_pkg.sv @@
// Package: shared types, format codes and character helpers for the integer formatter.
package itoa_fmt_pkg;

   localparam int MAX_DIGITS = 16;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int SIDX_W     = $clog2(MAX_DIGITS);

   localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

   localparam logic [2:0] FMT_SDEC = 3'd0;
   localparam logic [2:0] FMT_UDEC = 3'd1;
   localparam logic [2:0] FMT_HEXL = 3'd2;
   localparam logic [2:0] FMT_HEXU = 3'd3;
   localparam logic [2:0] FMT_PTR  = 3'd4;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_X     = 8'h78;

   // reciprocal of ten scaled by 2^35
   localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [63:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  char_out;
      logic        last_char;
      logic [30:0] running_total;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEC_MUL,
      ST_DEC_STEP,
      ST_HEX,
      ST_EMIT
   } state_type;

   typedef enum logic {
      PRE_MINUS,
      PRE_HEX
   } prefix_type;

   function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
      logic [7:0] ch;
      if (digit < 4'd10) begin
         ch = CH_ZERO + {4'b0, digit};
      end else if (upper) begin
         ch = 8'h41 + {4'b0, digit - 4'd10};
      end else begin
         ch = 8'h61 + {4'b0, digit - 4'd10};
      end
      return ch;
   endfunction

endpackage

@@ sv/itoa_fmt_div10.sv @@
// Divide-by-ten unit: registered reciprocal multiply, then quotient and remainder.
module itoa_fmt_div10 (
   input  logic        clock,
   input  logic [31:0] operand,
   output logic [31:0] quot,
   output logic [3:0]  rem
);
   import itoa_fmt_pkg::*;

   logic [63:0] prod_ff, prod_in;
   logic [31:0] op_ff, op_in;
   logic [31:0] times_ten;
   logic [31:0] rem_full;

   assign prod_in = {32'b0, operand} * {32'b0, RECIP10};
   assign op_in   = operand;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      op_ff   <= op_in;
   end

   always_comb begin
      quot      = {3'b0, prod_ff[63:35]};
      times_ten = {quot[28:0], 3'b0} + {quot[30:0], 1'b0};
      rem_full  = op_ff - times_ten;
      rem       = rem_full[3:0];
   end

endmodule

@@ sv/integer_to_ascii_formatter_top.sv @@
// Top level: integer to ASCII formatter with digit sequencer, digit stack and output register.
//
//   channel | direction | handshake        | payload
//   req     | in        | req_valid/stall  | req_payload_type  (format code, value)
//   rsp     | out       | rsp_valid/stall  | rsp_payload_type  (char, last, total)
//
// A transaction is taken in the idle state, then each digit is made in decimal (multiply
// by the reciprocal of ten, then correct and push) or in hex (nibble shift); then the
// characters leave one at a time through the output register.
// req_stall is high from acceptance until the last character is loaded.
// rsp_stall holds the output register; character generation waits for it.
// Synchronous reset clears the sequencer, the character count and the output valid.
module integer_to_ascii_formatter_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  itoa_fmt_pkg::req_payload_type req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output itoa_fmt_pkg::rsp_payload_type rsp_data
);
   import itoa_fmt_pkg::*;

   state_type       state_ff, state_in;
   logic [63:0]     work_ff, work_in;
   logic [CNT_W-1:0] digits_ff, digits_in;
   logic [1:0]      pre_ff, pre_in;
   prefix_type      pkind_ff, pkind_in;
   logic            upper_ff, upper_in;
   logic [30:0]     count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [3:0]      stack [MAX_DIGITS];
   logic            stack_we;
   logic [3:0]      stack_wdata;
   logic [3:0]      stack_rdata_ff;
   logic [CNT_W-1:0] digits_next;
   logic [CNT_W-1:0] rd_idx;
   logic [CNT_W-1:0] rd_idx_next;
   logic [31:0]     quot;
   logic [3:0]      rem;
   logic [31:0]     low;
   logic            load_ok;

   itoa_fmt_div10 u_div10 (
      .clock   (clock),
      .operand (work_ff[31:0]),
      .quot    (quot),
      .rem     (rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      digits_ff   <= digits_in;
      pre_ff      <= pre_in;
      pkind_ff    <= pkind_in;
      upper_ff    <= upper_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a push always lands on the entry read next, so forward the write data
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack[digits_ff[SIDX_W-1:0]] <= stack_wdata;
         stack_rdata_ff               <= stack_wdata;
      end else begin
         stack_rdata_ff <= stack[rd_idx_next[SIDX_W-1:0]];
      end
   end

   assign rd_idx      = digits_ff - CNT_W'(1);
   assign rd_idx_next = digits_in - CNT_W'(1);
   assign digits_next = digits_ff + CNT_W'(1);
   assign low         = req_data.value[31:0];
   assign load_ok     = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      digits_in    = digits_ff;
      pre_in       = pre_ff;
      pkind_in     = pkind_ff;
      upper_in     = upper_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      stack_we     = 1'b0;
      stack_wdata  = rem;
      req_stall    = (state_ff != ST_IDLE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            digits_in = '0;
            pre_in    = 2'd0;
            pkind_in  = PRE_MINUS;
            upper_in  = (req_data.req_type == FMT_HEXU);
            work_in   = {32'b0, low};
            if (req_valid) begin
               case (req_data.req_type)
                  FMT_SDEC: begin
                     state_in = ST_DEC_MUL;
                     if (low[31]) begin
                        work_in = {32'b0, ~low + 32'd1};
                        pre_in  = 2'd1;
                     end
                  end
                  FMT_UDEC: state_in = ST_DEC_MUL;
                  FMT_HEXL, FMT_HEXU: state_in = ST_HEX;
                  FMT_PTR: begin
                     state_in = ST_HEX;
                     work_in  = req_data.value;
                     pre_in   = 2'd2;
                     pkind_in = PRE_HEX;
                  end
                  default: state_in = ST_IDLE;  // unknown format: dropped
               endcase
            end
         end
         ST_DEC_MUL: begin
            state_in = ST_DEC_STEP;
         end
         ST_DEC_STEP: begin
            stack_we    = 1'b1;
            stack_wdata = rem;
            work_in     = {32'b0, quot};
            digits_in   = digits_next;
            if (quot != 32'd0 && digits_next < CNT_W'(MAX_DIGITS)) begin
               state_in = ST_DEC_MUL;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_HEX: begin
            stack_we    = 1'b1;
            stack_wdata = work_ff[3:0];
            work_in     = {4'b0, work_ff[63:4]};
            digits_in   = digits_next;
            if (work_ff[63:4] != 60'd0 && digits_next < CNT_W'(MAX_DIGITS)) begin
               state_in = ST_HEX;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_ok) begin
               count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 31'd1;
               rsp_valid_in              = 1'b1;
               rsp_data_in.running_total = count_in;
               rsp_data_in.last_char     = 1'b0;
               if (pre_ff != 2'd0) begin
                  pre_in = pre_ff - 2'd1;
                  if (pkind_ff == PRE_MINUS) begin
                     rsp_data_in.char_out = CH_MINUS;
                  end else if (pre_ff == 2'd2) begin
                     rsp_data_in.char_out = CH_ZERO;
                  end else begin
                     rsp_data_in.char_out = CH_X;
                  end
               end else begin
                  rsp_data_in.char_out = digit_char(stack_rdata_ff, upper_ff);
                  digits_in            = rd_idx;
                  if (digits_ff == CNT_W'(1)) begin
                     rsp_data_in.last_char = 1'b1;
                     state_in              = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
